/* rtl/scsr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scsr_pkg
// Shared types, widths and codes for the sparse CSR matrix store.
// ----------------------------------------------------------------------------
package scsr_pkg;

    localparam int MAX_ROWS_DEF    = 1024;
    localparam int MAX_ENTRIES_DEF = 4096;

    localparam int CMD_W      = 1;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 16;
    localparam int VAL_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int NUM_ROWS_W = 11;
    localparam int ENTRY_W    = COL_W + VAL_W;

    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = NUM_ROWS_W'(1024);

    localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } scsr_req_t;

    typedef struct packed {
        logic [VAL_W-1:0]    read_value;
        logic [STATUS_W-1:0] status;
    } scsr_result_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } scsr_entry_t;

    typedef enum logic {
        OP_INC,
        OP_DEC
    } step_op_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_LK_A,
        ST_LK_B,
        ST_LK_C,
        ST_SCAN,
        ST_CMP,
        ST_IN_A,
        ST_IN_B,
        ST_SH_RD,
        ST_SH_WR,
        ST_RS_RD,
        ST_RS_WR,
        ST_RESP
    } scsr_state_t;

endpackage
`default_nettype wire

/* rtl/scsr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scsr_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scsr_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/scsr_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scsr_step
// Shared step unit: increment or decrement one operand, compare it to another.
// ----------------------------------------------------------------------------
module scsr_step #(
    parameter int W = 13
) (
    input  wire logic [W-1:0]          a,
    input  wire logic [W-1:0]          b,
    input  wire scsr_pkg::step_op_t    op,
    output logic      [W-1:0]          y,
    output logic                       eq
);

    import scsr_pkg::*;

    always_comb
    begin
        unique case (op)
            OP_INC:  y = a + W'(1);
            OP_DEC:  y = a - W'(1);
            default: y = a;
        endcase
    end

    assign eq = (a == b);

endmodule
`default_nettype wire

/* rtl/scsr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scsr_ctrl
// Sequencer for insert and lookup: walks row starts and entries through the
// shared step unit, one memory access at a time.
// ----------------------------------------------------------------------------
module scsr_ctrl #(
    parameter int MAX_ROWS    = scsr_pkg::MAX_ROWS_DEF,
    parameter int MAX_ENTRIES = scsr_pkg::MAX_ENTRIES_DEF,
    parameter int RI_W        = 11,
    parameter int EC_W        = 13,
    parameter int EA_W        = 12,
    parameter int UW          = 13
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire scsr_pkg::scsr_req_t                 req,
    input  wire logic [scsr_pkg::NUM_ROWS_W-1:0]     num_rows,
    input  wire logic                                out_free,
    output logic                                     done,
    output scsr_pkg::scsr_result_t                   res,
    output logic                                     rs_we,
    output logic      [RI_W-1:0]                     rs_waddr,
    output logic      [EC_W-1:0]                     rs_wdata,
    output logic      [RI_W-1:0]                     rs_raddr,
    input  wire logic [EC_W-1:0]                     rs_rdata,
    output logic                                     en_we,
    output logic      [EA_W-1:0]                     en_waddr,
    output logic      [scsr_pkg::ENTRY_W-1:0]        en_wdata,
    output logic      [EA_W-1:0]                     en_raddr,
    input  wire logic [scsr_pkg::ENTRY_W-1:0]        en_rdata
);

    import scsr_pkg::*;

    localparam int CW0 = (RI_W > NUM_ROWS_W) ? RI_W : NUM_ROWS_W;
    localparam int CW  = (CW0 > ROW_W) ? CW0 : ROW_W;

    scsr_state_t  state_reg, state_next;
    scsr_req_t    req_reg, req_next;
    scsr_result_t res_reg, res_next;
    logic [EC_W-1:0] ptr_reg, ptr_next;
    logic [EC_W-1:0] end_reg, end_next;
    logic [EC_W-1:0] pos_reg, pos_next;
    logic [EC_W-1:0] total_reg, total_next;
    logic [RI_W-1:0] r_reg, r_next;
    logic [RI_W-1:0] wa_reg, wa_next;

    logic [UW-1:0] alu_a, alu_b, alu_y;
    step_op_t      alu_op;
    logic          alu_eq;

    logic [RI_W-1:0] rowi;
    logic [CW-1:0]   row_ext;
    logic            out_rng;
    logic            full;
    scsr_entry_t     ent;

    scsr_step #(
        .W (UW)
    ) u_step (
        .a  (alu_a),
        .b  (alu_b),
        .op (alu_op),
        .y  (alu_y),
        .eq (alu_eq)
    );

    assign rowi    = RI_W'(req_reg.row);
    assign row_ext = CW'(req.row);
    assign out_rng = (row_ext >= CW'(num_rows)) || (row_ext >= CW'(MAX_ROWS));
    assign full    = (total_reg == EC_W'(MAX_ENTRIES));
    assign ent     = en_rdata;
    assign res     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            total_reg <= '0;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            r_reg     <= r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        ptr_reg <= ptr_next;
        end_reg <= end_next;
        pos_reg <= pos_next;
        wa_reg  <= wa_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        r_next     = r_reg;
        wa_next    = wa_reg;
        alu_a      = '0;
        alu_b      = '0;
        alu_op     = OP_INC;
        rs_we      = 1'b0;
        rs_waddr   = r_reg;
        rs_wdata   = '0;
        rs_raddr   = r_reg;
        en_we      = 1'b0;
        en_waddr   = ptr_reg[EA_W-1:0];
        en_wdata   = en_rdata;
        en_raddr   = ptr_reg[EA_W-1:0];
        in_stall   = 1'b1;
        done       = 1'b0;

        unique case (state_reg)
            ST_CLR:
            begin
                // clearing pass over the row start table
                rs_we    = 1'b1;
                rs_waddr = r_reg;
                rs_wdata = '0;
                alu_a    = UW'(r_reg);
                if (r_reg == RI_W'(MAX_ROWS))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    r_next = alu_y[RI_W-1:0];
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    req_next = req;
                    if (out_rng)
                    begin
                        res_next   = '{read_value: '0, status: STATUS_RANGE};
                        state_next = ST_RESP;
                    end
                    else if (req.cmd == CMD_INSERT && full)
                    begin
                        res_next   = '{read_value: '0, status: STATUS_FULL};
                        state_next = ST_RESP;
                    end
                    else if (req.cmd == CMD_INSERT)
                    begin
                        state_next = ST_IN_A;
                    end
                    else
                    begin
                        state_next = ST_LK_A;
                    end
                end
            end
            ST_IN_A:
            begin
                alu_a      = UW'(rowi);
                rs_raddr   = alu_y[RI_W-1:0];
                r_next     = alu_y[RI_W-1:0];
                state_next = ST_IN_B;
            end
            ST_IN_B:
            begin
                pos_next   = rs_rdata;
                ptr_next   = total_reg;
                state_next = ST_SH_RD;
            end
            ST_SH_RD:
            begin
                alu_a  = UW'(ptr_reg);
                alu_b  = UW'(pos_reg);
                alu_op = OP_DEC;
                if (alu_eq)
                begin
                    // gap is open: drop the new word in
                    en_we      = 1'b1;
                    en_waddr   = pos_reg[EA_W-1:0];
                    en_wdata   = {req_reg.col, req_reg.value};
                    state_next = ST_RS_RD;
                end
                else
                begin
                    en_raddr   = alu_y[EA_W-1:0];
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR:
            begin
                alu_a      = UW'(ptr_reg);
                alu_op     = OP_DEC;
                en_we      = 1'b1;
                en_waddr   = ptr_reg[EA_W-1:0];
                en_wdata   = en_rdata;
                ptr_next   = alu_y[EC_W-1:0];
                state_next = ST_SH_RD;
            end
            ST_RS_RD:
            begin
                rs_raddr   = r_reg;
                wa_next    = r_reg;
                alu_a      = UW'(r_reg);
                r_next     = alu_y[RI_W-1:0];
                state_next = ST_RS_WR;
            end
            ST_RS_WR:
            begin
                alu_a    = UW'(rs_rdata);
                rs_we    = 1'b1;
                rs_waddr = wa_reg;
                rs_wdata = alu_y[EC_W-1:0];
                if (wa_reg == RI_W'(MAX_ROWS))
                begin
                    total_next = alu_y[EC_W-1:0];
                    res_next   = '{read_value: '0, status: STATUS_OK};
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_RS_RD;
                end
            end
            ST_LK_A:
            begin
                rs_raddr   = rowi;
                state_next = ST_LK_B;
            end
            ST_LK_B:
            begin
                alu_a      = UW'(rowi);
                rs_raddr   = alu_y[RI_W-1:0];
                ptr_next   = rs_rdata;
                state_next = ST_LK_C;
            end
            ST_LK_C:
            begin
                end_next   = rs_rdata;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                alu_a = UW'(ptr_reg);
                alu_b = UW'(end_reg);
                if (alu_eq)
                begin
                    res_next   = '{read_value: '0, status: STATUS_OK};
                    state_next = ST_RESP;
                end
                else
                begin
                    en_raddr   = ptr_reg[EA_W-1:0];
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                alu_a = UW'(ptr_reg);
                if (ent.col == req_reg.col)
                begin
                    res_next   = '{read_value: ent.value, status: STATUS_OK};
                    state_next = ST_RESP;
                end
                else
                begin
                    ptr_next   = alu_y[EC_W-1:0];
                    state_next = ST_SCAN;
                end
            end
            ST_RESP:
            begin
                done = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/sparse_csr_store_insert_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_csr_store_insert_lookup
// Sparse 16-bit matrix store in compressed sparse row form.
// ----------------------------------------------------------------------------
// One word is worked on at a time; in_stall is high from acceptance until the
// result is placed in the output register. After reset the row start table is
// cleared one entry per cycle, all MAX_ROWS + 1 entries, before the first word is
// taken (num_rows writes are taken meanwhile). A rejected word (row out of range,
// or insert into a full store) goes straight to the response. A lookup scans the
// entries of its row in turn until the column matches or the row ends. An insert
// moves the m entries after the insert point up by one, then increments the
// MAX_ROWS - row row starts after it: the shared step unit and the single read
// port of each memory move one entry, then one row start, at a time.
// ----------------------------------------------------------------------------
module sparse_csr_store_insert_lookup #(
    parameter int MAX_ROWS    = scsr_pkg::MAX_ROWS_DEF,
    parameter int MAX_ENTRIES = scsr_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [scsr_pkg::NUM_ROWS_W-1:0]   cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [scsr_pkg::CMD_W-1:0]        cmd,
    input  wire logic [scsr_pkg::ROW_W-1:0]        row,
    input  wire logic [scsr_pkg::COL_W-1:0]        col,
    input  wire logic [scsr_pkg::VAL_W-1:0]        value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [scsr_pkg::VAL_W-1:0]        read_value,
    output logic      [scsr_pkg::STATUS_W-1:0]     status
);

    import scsr_pkg::*;

    localparam int RI_W = $clog2(MAX_ROWS + 1);
    localparam int EC_W = $clog2(MAX_ENTRIES + 1);
    localparam int EA_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int UW   = (EC_W > RI_W) ? EC_W : RI_W;

    logic [NUM_ROWS_W-1:0] num_rows_reg;
    logic                  out_valid_reg;
    scsr_result_t          out_data_reg;

    scsr_req_t    req;
    scsr_result_t res;
    logic         done;
    logic         out_free;

    logic            rs_we;
    logic [RI_W-1:0] rs_waddr, rs_raddr;
    logic [EC_W-1:0] rs_wdata, rs_rdata;
    logic               en_we;
    logic [EA_W-1:0]    en_waddr, en_raddr;
    logic [ENTRY_W-1:0] en_wdata, en_rdata;

    assign req      = '{cmd: cmd, row: row, col: col, value: value};
    assign out_free = !out_valid_reg || !out_stall;

    scsr_ctrl #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .RI_W        (RI_W),
        .EC_W        (EC_W),
        .EA_W        (EA_W),
        .UW          (UW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req      (req),
        .num_rows (num_rows_reg),
        .out_free (out_free),
        .done     (done),
        .res      (res),
        .rs_we    (rs_we),
        .rs_waddr (rs_waddr),
        .rs_wdata (rs_wdata),
        .rs_raddr (rs_raddr),
        .rs_rdata (rs_rdata),
        .en_we    (en_we),
        .en_waddr (en_waddr),
        .en_wdata (en_wdata),
        .en_raddr (en_raddr),
        .en_rdata (en_rdata)
    );

    // row start table, last slot is the total entry count
    scsr_ram #(
        .DW    (EC_W),
        .DEPTH (MAX_ROWS + 1),
        .AW    (RI_W)
    ) u_row_starts (
        .clk   (clk),
        .we    (rs_we),
        .waddr (rs_waddr),
        .wdata (rs_wdata),
        .raddr (rs_raddr),
        .rdata (rs_rdata)
    );

    // packed column and value store
    scsr_ram #(
        .DW    (ENTRY_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (EA_W)
    ) u_entries (
        .clk   (clk),
        .we    (en_we),
        .waddr (en_waddr),
        .wdata (en_wdata),
        .raddr (en_raddr),
        .rdata (en_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= NUM_ROWS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                num_rows_reg <= cfg_wr_data;
            end
            if (done && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && out_free)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_data_reg.read_value;
    assign status     = out_data_reg.status;

endmodule
`default_nettype wire

/* rtl/scsr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scsr_checker
// Port-level checks for the sparse CSR matrix store.
// ----------------------------------------------------------------------------
module scsr_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [scsr_pkg::VAL_W-1:0]        read_value,
    input  wire logic [scsr_pkg::STATUS_W-1:0]     status
);

    import scsr_pkg::*;

    // a word is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(read_value) && $stable(status))
        else $error("result changed while stalled");

    // one word in flight: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted a second word while busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> read_value == '0)
        else $error("error result carries a value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK) || (status == STATUS_FULL)
            || (status == STATUS_RANGE))
        else $error("undefined status code");

endmodule

bind sparse_csr_store_insert_lookup scsr_checker u_scsr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .status     (status)
);
`default_nettype wire
